>>> hw/rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared sizes, types and state codes for the byte set statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bss_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int DATA_W      = 8;
    localparam int CNT_W       = 7;
    localparam int SUM_W       = 14;
    localparam int BIT_W       = 3;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] quotient;
    } t_div_out;

endpackage

>>> hw/rtl/bss_ram.sv
// ----------------------------------------------------------------------------
// bss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/bss_div.sv
// ----------------------------------------------------------------------------
// bss_div
// Restoring divider: sum by sample count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bss_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bss_pkg::SUM_W-1:0]   i_dividend,
    input  logic [bss_pkg::CNT_W-1:0]   i_divisor,
    output bss_pkg::t_div_out           o_div
);

    localparam int STEP_W = $clog2(bss_pkg::SUM_W + 1);

    logic [bss_pkg::SUM_W-1:0] r_quo;
    logic [bss_pkg::CNT_W-1:0] r_rem;
    logic [bss_pkg::CNT_W-1:0] r_dvs;
    logic [STEP_W-1:0]         r_step;
    logic                      r_busy;
    logic [bss_pkg::CNT_W:0]   shifted;
    logic                      fits;

    assign shifted = {r_rem, r_quo[bss_pkg::SUM_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(bss_pkg::SUM_W);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= bss_pkg::CNT_W'(shifted - {1'b0, r_dvs});
            end else begin
                r_rem <= shifted[bss_pkg::CNT_W-1:0];
            end
            r_quo <= {r_quo[bss_pkg::SUM_W-2:0], fits};
        end
    end

    // a zero count gives a zero mean
    assign o_div.busy     = r_busy;
    assign o_div.quotient = (r_dvs == '0) ? '0 : r_quo[bss_pkg::DATA_W-1:0];

endmodule

>>> hw/rtl/byte_set_statistics.sv
// Samples load at one item per cycle while the set is open.
// After the item marked last: 8 median passes, each a scan of the n stored samples,
// a drain and a decide step, then the result is registered; the passes
// are bound by the single read port of the sample RAM, the divider runs alongside.
// Input is held off from the last item until the result is registered.
// Reset (synchronous, active low) clears count, sum, max, min and overflow flag.
// ----------------------------------------------------------------------------
// byte_set_statistics
// Mean, median, maximum and minimum of a set of unsigned byte samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_set_statistics (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bss_pkg::DATA_W-1:0]   i_sample,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bss_pkg::DATA_W-1:0]   o_mean_value,
    output logic [bss_pkg::DATA_W-1:0]   o_median_value,
    output logic [bss_pkg::DATA_W-1:0]   o_maximum_value,
    output logic [bss_pkg::DATA_W-1:0]   o_minimum_value,
    output logic [bss_pkg::CNT_W-1:0]    o_sample_count,
    output logic                         o_overflow
);

    bss_pkg::t_state              r_state, n_state;
    logic [bss_pkg::CNT_W-1:0]    r_count;
    logic [bss_pkg::SUM_W-1:0]    r_sum;
    logic [bss_pkg::DATA_W-1:0]   r_max;
    logic [bss_pkg::DATA_W-1:0]   r_min;
    logic                         r_drop;
    logic [bss_pkg::ADDR_W-1:0]   r_addr;
    logic                         r_rd_vld;
    logic [bss_pkg::CNT_W-1:0]    r_tally;
    logic [bss_pkg::DATA_W-1:0]   r_med;
    logic [bss_pkg::BIT_W-1:0]    r_bit;
    logic                         r_div_go;

    logic                         accept;
    logic                         store;
    logic                         finish;
    logic [bss_pkg::DATA_W-1:0]   rdata;
    logic [bss_pkg::DATA_W-1:0]   cand;
    logic                         last_addr;
    bss_pkg::t_div_out            div;

    assign o_ready   = (r_state == bss_pkg::S_LOAD);
    assign accept    = i_valid && o_ready;
    assign store     = accept && (r_count < bss_pkg::CNT_W'(bss_pkg::MAX_SAMPLES));
    assign cand      = r_med | (bss_pkg::DATA_W'(1) << r_bit);
    assign last_addr = (bss_pkg::CNT_W'(r_addr) == r_count - 1'b1);
    assign finish    = (r_state == bss_pkg::S_FINISH) && !div.busy && !r_div_go
                       && (!o_valid || i_ready);

    bss_ram #(
        .WIDTH (bss_pkg::DATA_W),
        .DEPTH (bss_pkg::MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_count[bss_pkg::ADDR_W-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    bss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_div      (div)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            bss_pkg::S_LOAD: begin
                if (accept && i_last) begin
                    n_state = bss_pkg::S_SCAN;
                end
            end
            bss_pkg::S_SCAN: begin
                if (last_addr) begin
                    n_state = bss_pkg::S_DRAIN;
                end
            end
            bss_pkg::S_DRAIN: begin
                n_state = bss_pkg::S_DECIDE;
            end
            bss_pkg::S_DECIDE: begin
                n_state = (r_bit == '0) ? bss_pkg::S_FINISH : bss_pkg::S_SCAN;
            end
            bss_pkg::S_FINISH: begin
                if (finish) begin
                    n_state = bss_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = bss_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bss_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // running set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_max    <= '0;
            r_min    <= '1;
            r_drop   <= 1'b0;
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_div_go <= accept && i_last;
            if (store) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + bss_pkg::SUM_W'(i_sample);
                if (i_sample > r_max) begin
                    r_max <= i_sample;
                end
                if (i_sample < r_min) begin
                    r_min <= i_sample;
                end
            end else if (accept) begin
                r_drop <= 1'b1;
            end
            if (finish) begin
                r_count <= '0;
                r_sum   <= '0;
                r_max   <= '0;
                r_min   <= '1;
                r_drop  <= 1'b0;
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // median search, one value bit per pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_rd_vld <= (r_state == bss_pkg::S_SCAN);
            if (r_state == bss_pkg::S_SCAN && !last_addr) begin
                r_addr <= r_addr + 1'b1;
            end else if (r_state != bss_pkg::S_SCAN) begin
                r_addr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bss_pkg::S_LOAD) begin
            r_med   <= '0;
            r_bit   <= '1;
            r_tally <= '0;
        end else if (r_state == bss_pkg::S_DECIDE) begin
            if (r_tally > (r_count >> 1)) begin
                r_med <= cand;
            end
            r_bit   <= r_bit - 1'b1;
            r_tally <= '0;
        end else if (r_rd_vld && rdata >= cand) begin
            r_tally <= r_tally + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_mean_value    <= div.quotient;
            o_median_value  <= r_med;
            o_maximum_value <= r_max;
            o_minimum_value <= r_min;
            o_sample_count  <= r_count;
            o_overflow      <= r_drop;
        end
    end

`ifndef SYNTHESIS
    a_no_write_off_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store |-> (r_state == bss_pkg::S_LOAD))
        else $error("sample RAM written outside load");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bss_pkg::CNT_W'(bss_pkg::MAX_SAMPLES))
        else $error("stored count above capacity");

    a_median_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_median_value <= o_maximum_value
                            && o_median_value >= o_minimum_value))
        else $error("median outside min and max");

    a_div_done_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> !div.busy)
        else $error("result taken while divider busy");

    a_clear_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_count == '0 && !r_drop))
        else $error("set state not cleared after result");
`endif

endmodule

>>> tb/sv/byte_set_statistics_tb.sv
// ----------------------------------------------------------------------------
// byte_set_statistics_tb
// Self-checking bench for the byte set statistics block. Sets of byte
// samples are driven with random gaps while the result side stalls at
// random. An independent model predicts mean, median, maximum, minimum,
// count and overflow for every closed set and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_set_statistics_tb;

    localparam int DW    = bss_pkg::DATA_W;
    localparam int CW    = bss_pkg::CNT_W;
    localparam int DEPTH = bss_pkg::MAX_SAMPLES;

    typedef struct {
        logic [DW-1:0] sample;
        logic          last;
        int            gap;
        logic          hold;
    } t_sample_item;

    typedef struct {
        logic [DW-1:0] mean;
        logic [DW-1:0] median;
        logic [DW-1:0] maximum;
        logic [DW-1:0] minimum;
        logic [CW-1:0] count;
        logic          ovf;
    } t_set_stats;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [DW-1:0] i_sample;
    logic          i_last;
    logic          o_valid;
    logic          i_ready;
    logic [DW-1:0] o_mean_value;
    logic [DW-1:0] o_median_value;
    logic [DW-1:0] o_maximum_value;
    logic [DW-1:0] o_minimum_value;
    logic [CW-1:0] o_sample_count;
    logic          o_overflow;

    t_sample_item  pending_samples[$];
    t_set_stats    expected_stats[$];
    logic [DW-1:0] set_buf[$];

    // model state
    logic [DW-1:0] held_samples[DEPTH];
    int unsigned   held_count;
    logic [13:0]   sum_acc;
    logic [DW-1:0] peak;
    logic [DW-1:0] trough;
    logic          dropped;

    int   errors;
    int   total_items;
    int   taken_count;
    int   head_gap;
    logic in_taken;
    int   stall_left;
    int   phase_count;
    logic ready_calm;

    byte_set_statistics DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_mean_value    (o_mean_value),
        .o_median_value  (o_median_value),
        .o_maximum_value (o_maximum_value),
        .o_minimum_value (o_minimum_value),
        .o_sample_count  (o_sample_count),
        .o_overflow      (o_overflow)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DW-1:0] pick_sample(input int mode, input int base);
        int v;
        case (mode)
            1: begin
                v = ($urandom_range(0, 1) != 0) ? 255 : 0;
                if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 255);
            end
            2: begin
                v = base + $urandom_range(0, 6) - 3;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            3: v = base;
            default: v = $urandom_range(0, 255);
        endcase
        return v[DW-1:0];
    endfunction

    task automatic emit_set(input logic calm, input logic hold_first);
        t_sample_item it;
        for (int i = 0; i < set_buf.size(); i++) begin
            it.sample = set_buf[i];
            it.last   = (i == set_buf.size() - 1);
            it.gap    = calm ? 0 : pick_gap();
            it.hold   = hold_first && (i == 0);
            pending_samples.push_back(it);
        end
    endtask

    task automatic build_random_set(input int n, input logic calm, input logic hold_first);
        int mode;
        int base;
        mode = $urandom_range(0, 5);
        base = $urandom_range(0, 255);
        set_buf = {};
        for (int i = 0; i < n; i++) set_buf.push_back(pick_sample(mode, base));
        emit_set(calm, hold_first);
    endtask

    function automatic logic [DW-1:0] descending_middle(input int n);
        logic [DW-1:0] work[DEPTH];
        logic [DW-1:0] v;
        int            j;
        for (int i = 0; i < n; i++) work[i] = held_samples[i];
        for (int i = 1; i < n; i++) begin
            v = work[i];
            j = i;
            while (j > 0 && work[j-1] < v) begin
                work[j] = work[j-1];
                j--;
            end
            work[j] = v;
        end
        return work[n/2];
    endfunction

    task automatic absorb_sample(input logic [DW-1:0] s, input logic fin);
        t_set_stats r;
        if (held_count < DEPTH) begin
            held_samples[held_count] = s;
            held_count++;
            sum_acc = sum_acc + s;
            if (s > peak) peak = s;
            if (s < trough) trough = s;
        end else begin
            dropped = 1'b1;
        end
        if (fin) begin
            r.mean    = (held_count != 0) ? DW'(sum_acc / held_count) : '0;
            r.median  = descending_middle(held_count);
            r.maximum = peak;
            r.minimum = trough;
            r.count   = CW'(held_count);
            r.ovf     = dropped;
            expected_stats.push_back(r);
            held_count = 0;
            sum_acc    = '0;
            peak       = '0;
            trough     = '1;
            dropped    = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // result side
    always @(posedge i_clk) begin : watch_ports
        t_set_stats want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_stats.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
            end else begin
                want = expected_stats.pop_front();
                check_field("mean_value", want.mean, o_mean_value);
                check_field("median_value", want.median, o_median_value);
                check_field("maximum_value", want.maximum, o_maximum_value);
                check_field("minimum_value", want.minimum, o_minimum_value);
                check_field("sample_count", DW'(want.count), DW'(o_sample_count));
                check_field("overflow", DW'(want.ovf), DW'(o_overflow));
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            absorb_sample(i_sample, i_last);
            taken_count++;
        end
        in_taken <= i_rst_n && i_valid && o_ready;
    end

    // sample side
    always @(negedge i_clk) begin : drive_samples
        logic          nxt_valid;
        logic [DW-1:0] nxt_sample;
        logic          nxt_last;
        nxt_valid  = i_valid;
        nxt_sample = i_sample;
        nxt_last   = i_last;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_valid || in_taken) begin
            nxt_valid = 1'b0;
            if (pending_samples.size() != 0) begin
                if (head_gap < 0) head_gap = pending_samples[0].gap;
                if (head_gap > 0) begin
                    head_gap--;
                end else if (!(pending_samples[0].hold && expected_stats.size() != 0)) begin
                    nxt_valid  = 1'b1;
                    nxt_sample = pending_samples[0].sample;
                    nxt_last   = pending_samples[0].last;
                    void'(pending_samples.pop_front());
                    head_gap = -1;
                end
            end
        end
        i_valid  <= nxt_valid;
        i_sample <= nxt_sample;
        i_last   <= nxt_last;
    end

    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if (!ready_calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
        phase_count <= phase_count + 1;
        if (phase_count % 200 == 0) ready_calm <= ($urandom_range(0, 2) == 0);
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_last      = 1'b0;
        i_ready     = 1'b0;
        in_taken    = 1'b0;
        stall_left  = 0;
        phase_count = 0;
        ready_calm  = 1'b0;
        head_gap    = -1;
        errors      = 0;
        taken_count = 0;
        held_count  = 0;
        sum_acc     = '0;
        peak        = '0;
        trough      = '1;
        dropped     = 1'b0;

        // directed sets
        set_buf = '{8'd0};
        emit_set(1'b0, 1'b0);
        set_buf = '{8'd255};
        emit_set(1'b0, 1'b0);
        set_buf = '{8'd255, 8'd0};
        emit_set(1'b0, 1'b0);
        set_buf = '{8'd0, 8'd128, 8'd255};
        emit_set(1'b1, 1'b0);
        set_buf = '{8'd170, 8'd85, 8'd1, 8'd254};
        emit_set(1'b0, 1'b0);
        set_buf = '{8'd7, 8'd7, 8'd7, 8'd7, 8'd7};
        emit_set(1'b0, 1'b0);
        set_buf = '{8'd3, 8'd9, 8'd1, 8'd9, 8'd3, 8'd200};
        emit_set(1'b0, 1'b0);

        // store exactly full, then overflow with the final three samples dropped
        build_random_set(DEPTH, 1'b0, 1'b1);
        build_random_set(DEPTH + 3, 1'b1, 1'b0);

        while (pending_samples.size() < 1320) begin
            int r;
            int n;
            r = $urandom_range(0, 99);
            if (r < 55)      n = $urandom_range(1, 8);
            else if (r < 80) n = $urandom_range(9, 32);
            else if (r < 90) n = $urandom_range(33, DEPTH - 1);
            else if (r < 95) n = DEPTH;
            else             n = $urandom_range(DEPTH + 1, DEPTH + 8);
            build_random_set(n, $urandom_range(0, 4) == 0, $urandom_range(0, 29) == 0);
        end
        total_items = pending_samples.size();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (taken_count == total_items);
        wait (expected_stats.size() == 0);
        repeat (8 * DEPTH + 40) @(posedge i_clk);
        if (errors == 0) begin
            $display("byte_set_statistics regression: pass");
        end else begin
            $display("byte_set_statistics regression: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("byte_set_statistics regression: fail");
        $finish;
    end

endmodule
